>>> rtl/depth_to_point_cloud_macros.svh
// ----------------------------------------------------------------------------
// depth_to_point_cloud_macros.svh
// Assertion macros used by the point cloud top level.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_POINT_CLOUD_MACROS_SVH
`define DEPTH_TO_POINT_CLOUD_MACROS_SVH

// Same-cycle implication.
`define DTPC_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dtpc assertion failed");

// Next-cycle implication.
`define DTPC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dtpc assertion failed");

`endif

>>> rtl/dtpc_pkg.sv
// ----------------------------------------------------------------------------
// dtpc_pkg
// Types and constants for the depth image to point cloud block.
// ----------------------------------------------------------------------------
package dtpc_pkg;

  localparam int MAGW = 14;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] REG_IMAGE_COLS = 3'd0;
  localparam logic [2:0] REG_IMAGE_ROWS = 3'd1;
  localparam logic [2:0] REG_INV_FOCAL  = 3'd2;
  localparam logic [2:0] REG_MIN_RANGE  = 3'd3;
  localparam logic [2:0] REG_MAX_RANGE  = 3'd4;
  localparam logic [2:0] REG_COLOR_MODE = 3'd5;

  localparam logic [1:0] COLOR_RGB  = 2'd0;
  localparam logic [1:0] COLOR_MONO = 2'd1;

  typedef struct packed {
    logic [11:0] image_cols;
    logic [11:0] image_rows;
    logic [23:0] inv_double_focal;
    logic [15:0] min_range;
    logic [15:0] max_range;
    logic [1:0]  color_mode;
  } cfg_t;

  // Classified pixel handed from front to back.
  typedef struct packed {
    logic [15:0]     depth;
    logic [MAGW-1:0] mag_x;
    logic            neg_x;
    logic [MAGW-1:0] mag_y;
    logic            neg_y;
    logic            valid;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            last;
    logic            dense;
  } fe_item_t;

  typedef struct packed {
    logic [23:0] x_pos;
    logic [23:0] y_pos;
    logic [15:0] z_dist;
    logic        point_valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_point;
    logic        frame_dense;
  } point_t;

endpackage

>>> rtl/dtpc_if.sv
// ----------------------------------------------------------------------------
// dtpc_if
// Stream interfaces for depth pixels in and points out.
// ----------------------------------------------------------------------------
interface dtpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_mm;
  logic [7:0]  color_a;
  logic [7:0]  color_b;
  logic [7:0]  color_c;

  modport source (output valid, depth_mm, color_a, color_b, color_c, input ready);
  modport sink   (input valid, depth_mm, color_a, color_b, color_c, output ready);
endinterface

interface dtpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] x_pos;
  logic signed [23:0] y_pos;
  logic [15:0]        z_dist;
  logic               point_valid;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               last_point;
  logic               frame_dense;

  modport source (output valid, x_pos, y_pos, z_dist, point_valid, red, green, blue,
                  last_point, frame_dense, input ready);
  modport sink   (input valid, x_pos, y_pos, z_dist, point_valid, red, green, blue,
                  last_point, frame_dense, output ready);
endinterface

>>> rtl/dtpc_front.sv
// ----------------------------------------------------------------------------
// dtpc_front
// Takes depth pixels, tracks raster position, range-checks and classifies.
// ----------------------------------------------------------------------------
module dtpc_front #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  dtpc_pkg::cfg_t     cfg,
  dtpc_in_if.sink            in_ch,
  output dtpc_pkg::fe_item_t item,
  output logic               push,
  input  logic               full
);
  import dtpc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [13:0] MAX_C = 14'(MAX_COLS);
  localparam logic [13:0] MAX_R = 14'(MAX_ROWS);

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic          dense_so_far;

  logic [11:0]     cols_eff, rows_eff;
  logic [13:0]     twice_x, twice_y, span_x, span_y;
  logic            neg_x, neg_y, valid, end_row, end_frame, dense;

  always_comb begin
    cols_eff = (cfg.image_cols == 12'd0) ? 12'd1 :
               ({2'b00, cfg.image_cols} > MAX_C) ? MAX_C[11:0] : cfg.image_cols;
    rows_eff = (cfg.image_rows == 12'd0) ? 12'd1 :
               ({2'b00, cfg.image_rows} > MAX_R) ? MAX_R[11:0] : cfg.image_rows;
    twice_x  = 14'(col_count) << 1;
    twice_y  = 14'(row_count) << 1;
    span_x   = 14'(cols_eff) - 14'd1;
    span_y   = 14'(rows_eff) - 14'd1;
    neg_x    = twice_x < span_x;
    neg_y    = twice_y < span_y;
    valid    = (in_ch.depth_mm > cfg.min_range) && (in_ch.depth_mm < cfg.max_range);
    end_row  = (14'(col_count) + 14'd1) >= 14'(cols_eff);
    end_frame = end_row && ((14'(row_count) + 14'd1) >= 14'(rows_eff));
    dense    = dense_so_far && valid;

    item.depth = valid ? in_ch.depth_mm : 16'd0;
    item.mag_x = neg_x ? (span_x - twice_x) : (twice_x - span_x);
    item.neg_x = neg_x;
    item.mag_y = neg_y ? (span_y - twice_y) : (twice_y - span_y);
    item.neg_y = neg_y;
    item.valid = valid;
    item.last  = end_frame;
    item.dense = end_frame && dense;
    case (cfg.color_mode)
      COLOR_RGB: begin
        item.red   = in_ch.color_a;
        item.green = in_ch.color_b;
        item.blue  = in_ch.color_c;
      end
      COLOR_MONO: begin
        item.red   = in_ch.color_a;
        item.green = in_ch.color_a;
        item.blue  = in_ch.color_a;
      end
      default: begin
        item.red   = 8'd0;
        item.green = 8'd0;
        item.blue  = 8'd0;
      end
    endcase
  end

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count    <= '0;
      row_count    <= '0;
      dense_so_far <= 1'b1;
    end else if (push) begin
      if (end_row) begin
        col_count <= '0;
        row_count <= end_frame ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
      dense_so_far <= end_frame ? 1'b1 : dense;
    end
  end
endmodule

>>> rtl/dtpc_queue.sv
// ----------------------------------------------------------------------------
// dtpc_queue
// Short FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module dtpc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dtpc_pkg::fe_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output dtpc_pkg::fe_item_t rd_item,
  output logic               empty
);
  import dtpc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  fe_item_t      entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full    = count == (PW+1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule

>>> rtl/dtpc_back.sv
// ----------------------------------------------------------------------------
// dtpc_back
// Three-stage projection pipe: depth x offset, x focal factor, round/saturate.
// ----------------------------------------------------------------------------
module dtpc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [23:0]        inv_double_focal,
  input  dtpc_pkg::fe_item_t q_item,
  input  logic               q_empty,
  output logic               q_pop,
  output dtpc_pkg::point_t   point,
  output logic               point_vld,
  input  logic               point_rdy
);
  import dtpc_pkg::*;

  function automatic logic [23:0] round_sat(input logic [53:0] prod, input logic neg);
    logic [54:0] sum;
    logic [30:0] q;
    logic [23:0] mag;
    begin
      sum = 55'(prod) + 55'(24'h800000);
      q   = sum[54:24];
      if (neg) begin
        mag = (q > 31'h800000) ? 24'h800000 : q[23:0];
        round_sat = ~mag + 24'd1;
      end else begin
        round_sat = (q > 31'h7FFFFF) ? 24'h7FFFFF : q[23:0];
      end
    end
  endfunction

  logic        adv;
  logic        a_vld, b_vld;
  fe_item_t    a_item, b_item;
  logic [29:0] a_px, a_py;
  logic [53:0] b_px, b_py;

  assign adv   = !point_vld || point_rdy;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      point_vld <= 1'b0;
    end else if (adv) begin
      a_vld     <= !q_empty;
      b_vld     <= a_vld;
      point_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= q_item;
      a_px   <= 30'(q_item.depth) * 30'(q_item.mag_x);
      a_py   <= 30'(q_item.depth) * 30'(q_item.mag_y);
      b_item <= a_item;
      b_px   <= 54'(a_px) * 54'(inv_double_focal);
      b_py   <= 54'(a_py) * 54'(inv_double_focal);
      point.x_pos       <= round_sat(b_px, b_item.neg_x);
      point.y_pos       <= round_sat(b_py, b_item.neg_y);
      point.z_dist      <= b_item.depth;
      point.point_valid <= b_item.valid;
      point.red         <= b_item.red;
      point.green       <= b_item.green;
      point.blue        <= b_item.blue;
      point.last_point  <= b_item.last;
      point.frame_dense <= b_item.dense;
    end
  end
endmodule

>>> rtl/depth_to_point_cloud.sv
// A pixel transaction is written into the queue, then passes the a and b stages to the point on the output register.
// Throughput: one pixel per cycle; the multiplier pipe stalls as a whole on output back-pressure.
// Front and back are decoupled by a 4-entry queue.
// Reset: position counters to zero, dense flag set, registers to defaults, queue and pipe empty.
// ----------------------------------------------------------------------------
// depth_to_point_cloud
// Pinhole depth image to coloured 3-D point stream, with configuration regs.
// ----------------------------------------------------------------------------
`include "depth_to_point_cloud_macros.svh"

module depth_to_point_cloud #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  dtpc_in_if.sink     in_ch,
  dtpc_out_if.source  out_ch
);
  import dtpc_pkg::*;

  cfg_t     cfg;
  fe_item_t fe_item, q_item;
  logic     push, full, pop, empty;
  point_t   point;
  logic     pt_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_cols       <= 12'd640;
      cfg.image_rows       <= 12'd480;
      cfg.inv_double_focal <= 24'd20000;
      cfg.min_range        <= 16'd100;
      cfg.max_range        <= 16'd10000;
      cfg.color_mode       <= COLOR_RGB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_COLS: cfg.image_cols       <= cfg_data[11:0];
        REG_IMAGE_ROWS: cfg.image_rows       <= cfg_data[11:0];
        REG_INV_FOCAL:  cfg.inv_double_focal <= cfg_data;
        REG_MIN_RANGE:  cfg.min_range        <= cfg_data[15:0];
        REG_MAX_RANGE:  cfg.max_range        <= cfg_data[15:0];
        REG_COLOR_MODE: cfg.color_mode       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  dtpc_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .in_ch (in_ch),
    .item  (fe_item),
    .push  (push),
    .full  (full)
  );

  dtpc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (fe_item),
    .full    (full),
    .pop     (pop),
    .rd_item (q_item),
    .empty   (empty)
  );

  dtpc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .inv_double_focal (cfg.inv_double_focal),
    .q_item           (q_item),
    .q_empty          (empty),
    .q_pop            (pop),
    .point            (point),
    .point_vld        (out_ch.valid),
    .point_rdy        (out_ch.ready)
  );

  assign out_ch.x_pos       = point.x_pos;
  assign out_ch.y_pos       = point.y_pos;
  assign out_ch.z_dist      = point.z_dist;
  assign out_ch.point_valid = point.point_valid;
  assign out_ch.red         = point.red;
  assign out_ch.green       = point.green;
  assign out_ch.blue        = point.blue;
  assign out_ch.last_point  = point.last_point;
  assign out_ch.frame_dense = point.frame_dense;

  assign pt_zero = (out_ch.x_pos == 24'sd0) && (out_ch.y_pos == 24'sd0) &&
                   (out_ch.z_dist == 16'd0);

  `DTPC_ASSERT_NOW(a_invalid_zero, clk, rst, out_ch.valid && !out_ch.point_valid, pt_zero)
  `DTPC_ASSERT_NOW(a_dense_only_last, clk, rst, out_ch.valid && !out_ch.last_point, !out_ch.frame_dense)
  `DTPC_ASSERT_NOW(a_dense_is_valid, clk, rst, out_ch.valid && out_ch.frame_dense, out_ch.point_valid)
  `DTPC_ASSERT_NEXT(a_no_push_when_full, clk, rst, full && !pop, !(push && full))
endmodule

>>> verif/point_cloud_checker.sv
// ----------------------------------------------------------------------------
// point_cloud_checker
// Watches the register port and both streams of the point cloud block. It
// keeps its own copy of the registers and position counters, works out the
// point for every accepted pixel and compares each accepted point, field by
// field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module point_cloud_checker #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  dtpc_in_if          pix,
  dtpc_out_if         pts,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dtpc_pkg::*;

  logic [11:0] cols_reg;
  logic [11:0] rows_reg;
  logic [23:0] focal_reg;
  logic [15:0] min_reg;
  logic [15:0] max_reg;
  logic [1:0]  mode_reg;

  logic [11:0] col_pos;
  logic [11:0] row_pos;
  logic        dense_acc;

  point_t owed_points[$];
  int     point_idx;

  initial begin
    fail_count = 0;
    pending    = 0;
    point_idx  = 0;
  end

  function automatic logic [12:0] clamp_size(logic [11:0] v, int limit);
    if (v == 12'd0) return 13'd1;
    if (int'(v) > limit) return 13'(limit);
    return {1'b0, v};
  endfunction

  // Offset along one axis, rounded half away from zero, saturated to 24 bits.
  function automatic logic [23:0] axis_mm(logic [15:0] depth, logic [11:0] pos,
                                          logic [12:0] size, logic [23:0] scale);
    logic [13:0] twice;
    logic [13:0] span;
    logic [13:0] mag;
    logic        neg;
    logic [63:0] q;
    twice = {1'b0, pos, 1'b0};
    span  = {1'b0, size} - 14'd1;
    neg   = twice < span;
    mag   = neg ? span - twice : twice - span;
    q = (64'(depth) * 64'(mag) * 64'(scale) + 64'h80_0000) >> 24;
    if (neg) begin
      if (q > 64'd8388608) q = 64'd8388608;
      return 24'(64'd0 - q);
    end
    if (q > 64'd8388607) q = 64'd8388607;
    return q[23:0];
  endfunction

  task automatic project_pixel(input logic [15:0] depth, input logic [7:0] ca,
                               input logic [7:0] cb, input logic [7:0] cc,
                               output point_t pt);
    logic [12:0] cols;
    logic [12:0] rows;
    logic        in_range;
    logic        row_end;
    logic        frame_end;
    logic        still_dense;
    cols        = clamp_size(cols_reg, MAX_COLS);
    rows        = clamp_size(rows_reg, MAX_ROWS);
    in_range    = (depth > min_reg) && (depth < max_reg);
    row_end     = ({1'b0, col_pos} + 13'd1) >= cols;
    frame_end   = row_end && (({1'b0, row_pos} + 13'd1) >= rows);
    still_dense = dense_acc && in_range;

    pt = '0;
    if (in_range) begin
      pt.x_pos  = axis_mm(depth, col_pos, cols, focal_reg);
      pt.y_pos  = axis_mm(depth, row_pos, rows, focal_reg);
      pt.z_dist = depth;
    end
    pt.point_valid = in_range;
    case (mode_reg)
      COLOR_RGB: begin
        pt.red   = ca;
        pt.green = cb;
        pt.blue  = cc;
      end
      COLOR_MONO: begin
        pt.red   = ca;
        pt.green = ca;
        pt.blue  = ca;
      end
      default: ;
    endcase
    pt.last_point  = frame_end;
    pt.frame_dense = frame_end && still_dense;

    if (row_end) begin
      col_pos = '0;
      row_pos = frame_end ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos = col_pos + 12'd1;
    end
    dense_acc = frame_end ? 1'b1 : still_dense;
  endtask

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < 40)
      $display("%0t: point %0d %s got 0x%0h want 0x%0h", $time, point_idx, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    point_t want;
    point_t next_pt;
    if (rst) begin
      cols_reg  = 12'd640;
      rows_reg  = 12'd480;
      focal_reg = 24'd20000;
      min_reg   = 16'd100;
      max_reg   = 16'd10000;
      mode_reg  = COLOR_RGB;
      col_pos   = '0;
      row_pos   = '0;
      dense_acc = 1'b1;
      owed_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_COLS: cols_reg  = cfg_data[11:0];
          REG_IMAGE_ROWS: rows_reg  = cfg_data[11:0];
          REG_INV_FOCAL:  focal_reg = cfg_data;
          REG_MIN_RANGE:  min_reg   = cfg_data[15:0];
          REG_MAX_RANGE:  max_reg   = cfg_data[15:0];
          REG_COLOR_MODE: mode_reg  = cfg_data[1:0];
          default: ;
        endcase
      end

      if (pts.valid && pts.ready) begin
        if (owed_points.size() == 0) begin
          report_mismatch("transaction with nothing owed", 32'd0, 32'd0);
        end else begin
          want = owed_points.pop_front();
          if (pts.x_pos !== want.x_pos)
            report_mismatch("x_pos", 32'(pts.x_pos), 32'(want.x_pos));
          if (pts.y_pos !== want.y_pos)
            report_mismatch("y_pos", 32'(pts.y_pos), 32'(want.y_pos));
          if (pts.z_dist !== want.z_dist)
            report_mismatch("z_dist", 32'(pts.z_dist), 32'(want.z_dist));
          if (pts.point_valid !== want.point_valid)
            report_mismatch("point_valid", 32'(pts.point_valid), 32'(want.point_valid));
          if (pts.red !== want.red)
            report_mismatch("red", 32'(pts.red), 32'(want.red));
          if (pts.green !== want.green)
            report_mismatch("green", 32'(pts.green), 32'(want.green));
          if (pts.blue !== want.blue)
            report_mismatch("blue", 32'(pts.blue), 32'(want.blue));
          if (pts.last_point !== want.last_point)
            report_mismatch("last_point", 32'(pts.last_point), 32'(want.last_point));
          if (pts.frame_dense !== want.frame_dense)
            report_mismatch("frame_dense", 32'(pts.frame_dense), 32'(want.frame_dense));
        end
        point_idx++;
      end

      if (pix.valid && pix.ready) begin
        project_pixel(pix.depth_mm, pix.color_a, pix.color_b, pix.color_c, next_pt);
        owed_points.push_back(next_pt);
      end
    end
    pending <= owed_points.size();
  end

endmodule

>>> verif/depth_to_point_cloud_tb.sv
// ----------------------------------------------------------------------------
// depth_to_point_cloud_tb
// Drives depth pixels into the point cloud block under random stalls on both
// streams. A short directed run covers range limits, saturation, size
// clamping, a size shrunk mid-frame and every colour mode; random phases
// with fresh register settings follow. The checker does the comparing.
// ----------------------------------------------------------------------------
module depth_to_point_cloud_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtpc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 12;
  localparam int PHASES      = 8;

  localparam logic [1:0] COLOR_NONE  = 2'd2;
  localparam logic [1:0] COLOR_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  int          fail_count;
  int          pending;
  int          quiet;
  bit          stalls_on;
  int          lo_mm;
  int          hi_mm;

  dtpc_in_if  pix();
  dtpc_out_if pts();

  depth_to_point_cloud #(
    .MAX_COLS(2048),
    .MAX_ROWS(2048)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (pix),
    .out_ch    (pts)
  );

  point_cloud_checker #(
    .MAX_COLS(2048),
    .MAX_ROWS(2048)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix        (pix),
    .pts        (pts),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : sink_pacing
    int hold;
    pts.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        pts.ready <= 1'b0;
      end else begin
        pts.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) hold = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (pts.valid && pts.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_pixel(input logic [15:0] d, input logic [7:0] a,
                            input logic [7:0] b, input logic [7:0] c);
    int gap;
    gap = stalls_on ? gap_len() : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid    <= 1'b1;
    pix.depth_mm <= d;
    pix.color_a  <= a;
    pix.color_b  <= b;
    pix.color_c  <= c;
    do @(posedge clk); while (!pix.ready);
  endtask

  task automatic send_random_colour(input logic [15:0] d);
    send_pixel(d, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stop sending, let every owed point out, then let the pipe settle.
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input int cols, input int rows, input int focal,
                            input int lo, input int hi, input logic [1:0] mode);
    drain();
    write_reg(REG_IMAGE_COLS, 24'(cols));
    write_reg(REG_IMAGE_ROWS, 24'(rows));
    write_reg(REG_INV_FOCAL, 24'(focal));
    write_reg(REG_MIN_RANGE, 24'(lo));
    write_reg(REG_MAX_RANGE, 24'(hi));
    write_reg(REG_COLOR_MODE, 24'(mode));
    cfg_we <= 1'b0;
    lo_mm = lo;
    hi_mm = hi;
  endtask

  function automatic logic [15:0] pick_depth();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'(lo_mm);
          1: return 16'(lo_mm + 1);
          2: return 16'(hi_mm - 1);
          default: return 16'(hi_mm);
        endcase
      end
      2: return 16'($urandom);
      default: begin
        if (lo_mm + 1 <= hi_mm - 1) return 16'($urandom_range(lo_mm + 1, hi_mm - 1));
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic random_config();
    int cols;
    int rows;
    int focal;
    int lo;
    int hi;
    case ($urandom_range(0, 19))
      0: cols = 0;
      1: cols = $urandom_range(2049, 4095);
      2, 3: cols = $urandom_range(100, 400);
      default: cols = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 19))
      0: rows = 0;
      1: rows = $urandom_range(2049, 4095);
      default: rows = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 9))
      0: focal = 0;
      1, 2: focal = 24'hFFFFFF;
      3: focal = $urandom_range(0, 24'hFFFFFF);
      default: focal = $urandom_range(8000, 40000);
    endcase
    case ($urandom_range(0, 9))
      0: lo = 0;
      1: lo = 65535;
      default: lo = $urandom_range(0, 600);
    endcase
    case ($urandom_range(0, 9))
      0: hi = 65535;
      1: hi = 0;
      2: hi = $urandom_range(0, 65535);
      default: hi = $urandom_range(2000, 20000);
    endcase
    set_config(cols, rows, focal, lo, hi, 2'($urandom_range(0, 3)));
  endtask

  initial begin : stimulus
    int n;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_IMAGE_COLS;
    cfg_data  <= '0;
    pix.valid <= 1'b0;
    pix.depth_mm <= '0;
    pix.color_a  <= '0;
    pix.color_b  <= '0;
    pix.color_c  <= '0;
    stalls_on = 1'b1;
    lo_mm     = 100;
    hi_mm     = 10000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset.
    send_pixel(16'd0, 8'h00, 8'h00, 8'h00);
    send_pixel(16'd5000, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'hFFFF, 8'hA5, 8'h5A, 8'h0F);

    // Oversize columns, zero rows, largest scale: negative saturation, mono.
    set_config(4095, 0, 24'hFFFFFF, 0, 65535, COLOR_MONO);
    send_pixel(16'd65534, 8'h81, 8'h7E, 8'h01);
    send_pixel(16'd1, 8'hFF, 8'h00, 8'hFF);
    send_pixel(16'd0, 8'h00, 8'hFF, 8'h00);
    send_pixel(16'hFFFF, 8'h55, 8'hAA, 8'h55);

    // Columns shrunk below the counter; empty range, colour modes 2 and 3.
    set_config(2, 2, 0, 1000, 1000, COLOR_SPARE);
    send_pixel(16'd1000, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd999, 8'h12, 8'h34, 8'h56);
    set_config(2, 2, 0, 1000, 1000, COLOR_NONE);
    send_pixel(16'd1001, 8'hFF, 8'hFF, 8'hFF);

    // Small frames: one fully dense, one with a point out of range.
    set_config(3, 2, 24'h100000, 100, 5000, COLOR_RGB);
    for (int i = 0; i < 6; i++) send_random_colour(16'(101 + i * 979));
    for (int i = 0; i < 6; i++) send_random_colour(i == 3 ? 16'd5000 : 16'd4999);

    for (int p = 0; p < PHASES; p++) begin
      random_config();
      stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(150, 230);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && $urandom_range(0, 1) == 0) stalls_on = !stalls_on;
        send_random_colour(pick_depth());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
